>>> rtl/tere_pkg.sv
// Shared types and constants for the touch event report encoder.
// No dependencies; imported by every module of the block.
`default_nettype none

package tere_pkg;

    localparam int IN_W   = 86;
    localparam int POS_W  = 14;
    localparam int TS_W   = 63;
    localparam int CFG_IW = 2;

    localparam logic [4:0] CMD_SYNC = 5'd0;
    localparam logic [4:0] CMD_KEY  = 5'd1;
    localparam logic [4:0] CMD_ABS  = 5'd3;

    localparam logic [9:0] AXIS_X = 10'd0;
    localparam logic [9:0] AXIS_Y = 10'd1;

    localparam logic [CFG_IW-1:0] REG_WIDTH  = 2'd0;
    localparam logic [CFG_IW-1:0] REG_HEIGHT = 2'd1;

    localparam logic [POS_W-1:0] WIDTH_RST  = 14'd800;
    localparam logic [POS_W-1:0] HEIGHT_RST = 14'd480;

    localparam logic [1:0] ACT_DOWN = 2'd0;
    localparam logic [1:0] ACT_UP   = 2'd1;
    localparam logic [1:0] ACT_MOVE = 2'd2;

    localparam logic [2:0] HDR_LAST = 3'd6;

    typedef struct packed {
        logic [TS_W-1:0]  ts;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [1:0]       action;
    } job_t;

    typedef enum logic [3:0] {
        EM_IDLE = 4'b0001,
        EM_HDR  = 4'b0010,
        EM_TS   = 4'b0100,
        EM_BODY = 4'b1000
    } em_state_t;

    function automatic logic [7:0] hdr_byte(input logic [2:0] idx);
        logic [7:0] b;
        case (idx)
            3'd0:    b = 8'h03;
            3'd1:    b = 8'h0b;
            3'd2:    b = 8'h03;
            3'd3:    b = 8'h00;
            3'd4:    b = 8'h80;
            3'd5:    b = 8'h01;
            3'd6:    b = 8'h08;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/tere_event.sv
// Event stage: input register, touch state, position scaling, sync job handoff.
// Depends on tere_pkg.
`default_nettype none

module tere_event
    import tere_pkg::*;
(
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    input  wire logic [IN_W-1:0]  s_tdata,
    input  wire logic [POS_W-1:0] screen_width,
    input  wire logic [POS_W-1:0] screen_height,
    output logic                  job_valid,
    input  wire logic             job_ready,
    output job_t                  job
);

    logic             in_valid_reg;
    logic [IN_W-1:0]  in_data_reg;
    logic [POS_W-1:0] x_pos_reg, x_pos_next;
    logic [POS_W-1:0] y_pos_reg, y_pos_next;
    logic             btn_now_reg, btn_now_next;
    logic             btn_before_reg, btn_before_next;
    logic             pending_reg, pending_next;

    logic [4:0]      cmd;
    logic [9:0]      code;
    logic [7:0]      val;
    logic [TS_W-1:0] ts;
    logic            take;

    // value * full / 255, division done as reciprocal steps with one correction
    function automatic logic [POS_W-1:0] scale_pos(input logic [7:0] v,
                                                   input logic [POS_W-1:0] full);
        logic [21:0]      p;
        logic [POS_W-1:0] q1;
        logic [14:0]      r;
        logic [6:0]       q2;
        logic [8:0]       r2;
        logic             c;
        p  = {14'd0, v} * {8'd0, full};
        q1 = p[21:8];
        r  = {7'd0, p[7:0]} + {1'b0, q1};
        q2 = r[14:8];
        r2 = {1'b0, r[7:0]} + {2'd0, q2};
        c  = (r2 >= 9'd255);
        return q1 + {7'd0, q2} + {13'd0, c};
    endfunction

    assign cmd  = in_data_reg[4:0];
    assign code = in_data_reg[14:5];
    assign val  = in_data_reg[22:15];
    assign ts   = in_data_reg[85:23];

    assign job_valid = in_valid_reg && (cmd == CMD_SYNC) && pending_reg;
    assign take      = in_valid_reg && (!job_valid || job_ready);
    assign s_tready  = !in_valid_reg || take;

    always_comb
    begin
        job.ts = ts;
        job.x  = x_pos_reg;
        job.y  = y_pos_reg;
        if (btn_now_reg && !btn_before_reg)
        begin
            job.action = ACT_DOWN;
        end
        else if (!btn_now_reg && btn_before_reg)
        begin
            job.action = ACT_UP;
        end
        else
        begin
            job.action = ACT_MOVE;
        end
    end

    always_comb
    begin
        x_pos_next      = x_pos_reg;
        y_pos_next      = y_pos_reg;
        btn_now_next    = btn_now_reg;
        btn_before_next = btn_before_reg;
        pending_next    = pending_reg;
        if (take)
        begin
            case (cmd)
                CMD_KEY:
                begin
                    btn_now_next = (val != 8'd0);
                    pending_next = 1'b1;
                end
                CMD_ABS:
                begin
                    if (code == AXIS_X)
                    begin
                        x_pos_next   = scale_pos(val, screen_width);
                        pending_next = 1'b1;
                    end
                    else if (code == AXIS_Y)
                    begin
                        y_pos_next   = scale_pos(val, screen_height);
                        pending_next = 1'b1;
                    end
                end
                CMD_SYNC:
                begin
                    if (pending_reg)
                    begin
                        btn_before_next = btn_now_reg;
                        pending_next    = 1'b0;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            x_pos_reg      <= '0;
            y_pos_reg      <= '0;
            btn_now_reg    <= 1'b0;
            btn_before_reg <= 1'b0;
            pending_reg    <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            x_pos_reg      <= x_pos_next;
            y_pos_reg      <= y_pos_next;
            btn_now_reg    <= btn_now_next;
            btn_before_reg <= btn_before_next;
            pending_reg    <= pending_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_data_reg <= s_tdata;
        end
    end

endmodule

`default_nettype wire

>>> rtl/tere_msg_emit.sv
// Message sequencer: header, timestamp varint, body bytes; output register.
// Depends on tere_pkg.
`default_nettype none

module tere_msg_emit
    import tere_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       job_valid,
    output logic            job_ready,
    input  wire job_t       job,
    output logic            m_tvalid,
    input  wire logic       m_tready,
    output logic [7:0]      m_tdata,
    output logic            m_tlast
);

    em_state_t       state_reg, state_next;
    logic [2:0]      hdr_cnt_reg, hdr_cnt_next;
    logic [4:0]      body_left_reg, body_left_next;
    logic [TS_W-1:0] ts_reg, ts_next;
    logic [127:0]    body_reg, body_next;
    logic            out_valid_reg, out_valid_next;
    logic [7:0]      out_byte_reg, out_byte_next;
    logic            out_last_reg, out_last_next;

    logic         out_free;
    logic         ts_more;
    logic         x_two, y_two;
    logic [7:0]   adj;
    logic [39:0]  head40;
    logic [47:0]  tail48;
    logic [127:0] body_load;

    assign out_free  = !out_valid_reg || m_tready;
    assign job_ready = (state_reg == EM_IDLE);
    assign ts_more   = |ts_reg[TS_W-1:7];

    assign x_two  = |job.x[13:7];
    assign y_two  = |job.y[13:7];
    assign adj    = 8'd2 + {7'd0, x_two} + {7'd0, y_two};
    assign head40 = {8'h08, 8'h04 + adj, 8'h0a, 8'h0a + adj, 8'h1a};
    assign tail48 = {6'd0, job.action, 8'h18, 8'h00, 8'h10, 8'h00, 8'h18};

    always_comb
    begin
        case ({x_two, y_two})
            2'b00: body_load = {16'd0, tail48, 1'b0, job.y[6:0], 8'h10,
                                1'b0, job.x[6:0], head40};
            2'b10: body_load = {8'd0, tail48, 1'b0, job.y[6:0], 8'h10,
                                1'b0, job.x[13:7], 1'b1, job.x[6:0], head40};
            2'b01: body_load = {8'd0, tail48, 1'b0, job.y[13:7], 1'b1, job.y[6:0],
                                8'h10, 1'b0, job.x[6:0], head40};
            default: body_load = {tail48, 1'b0, job.y[13:7], 1'b1, job.y[6:0], 8'h10,
                                  1'b0, job.x[13:7], 1'b1, job.x[6:0], head40};
        endcase
    end

    always_comb
    begin
        state_next     = state_reg;
        hdr_cnt_next   = hdr_cnt_reg;
        body_left_next = body_left_reg;
        ts_next        = ts_reg;
        body_next      = body_reg;
        out_valid_next = out_valid_reg;
        out_byte_next  = out_byte_reg;
        out_last_next  = out_last_reg;
        if (out_free)
        begin
            out_valid_next = 1'b0;
        end
        case (state_reg)
            EM_IDLE:
            begin
                if (job_valid)
                begin
                    state_next     = EM_HDR;
                    hdr_cnt_next   = 3'd0;
                    ts_next        = job.ts;
                    body_next      = body_load;
                    body_left_next = 5'd14 + {4'd0, x_two} + {4'd0, y_two};
                end
            end
            EM_HDR:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hdr_byte(hdr_cnt_reg);
                    out_last_next  = 1'b0;
                    hdr_cnt_next   = hdr_cnt_reg + 3'd1;
                    if (hdr_cnt_reg == HDR_LAST)
                    begin
                        state_next = EM_TS;
                    end
                end
            end
            EM_TS:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = {ts_more, ts_reg[6:0]};
                    out_last_next  = 1'b0;
                    ts_next        = {7'd0, ts_reg[TS_W-1:7]};
                    if (!ts_more)
                    begin
                        state_next = EM_BODY;
                    end
                end
            end
            EM_BODY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = body_reg[7:0];
                    out_last_next  = (body_left_reg == 5'd1);
                    body_next      = {8'd0, body_reg[127:8]};
                    body_left_next = body_left_reg - 5'd1;
                    if (body_left_reg == 5'd1)
                    begin
                        state_next = EM_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = EM_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= EM_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        hdr_cnt_reg   <= hdr_cnt_next;
        body_left_reg <= body_left_next;
        ts_reg        <= ts_next;
        body_reg      <= body_next;
        out_byte_reg  <= out_byte_next;
        out_last_reg  <= out_last_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_byte_reg;
    assign m_tlast  = out_last_reg;

endmodule

`default_nettype wire

>>> rtl/touch_event_report_encoder_core.sv
// Top level of the touch event report encoder: config registers and wiring.
// Depends on tere_pkg, tere_event, tere_msg_emit.
//
// Usage:
//   Input stream (s_*): one event per request. Key and absolute-axis events
//   update the held button level or scaled position; a sync event with an
//   update pending produces one touch message on the output stream.
//   Output stream (m_*): one message byte per request, m_tlast on the final
//   byte. A message is 22 to 32 bytes long.
//   Config channel (cfg_*): always ready; index 0 screen width, 1 screen
//   height, other indexes ignored. Write only while the block is idle.
// Timing:
//   Non-sync events are taken at one per cycle while no sync waits in the
//   input register. A sync event sits in the input register from its
//   request edge until the idle message sequencer takes it; its bytes
//   then pass through the output register onto m_tdata. The sequencer
//   sends one byte per cycle while m_tready does not stall it, and takes
//   no new message until the last byte of the current one is sent; a sync
//   that arrives meanwhile waits in the input register and holds s_tready low.
// Reset and stall:
//   Reset clears the position, button levels and pending mark and loads the
//   screen size defaults of 800 by 480. When m_tready is low the output
//   byte holds and the sequencer pauses; events keep being taken until a
//   second sync needs the sequencer.
`default_nettype none

module touch_event_report_encoder_core
    import tere_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_tvalid,
    output logic                   s_tready,
    input  wire logic [87:0]       s_tdata,   // cmd[4:0], event_code[14:5],
                                              // event_value[22:15],
                                              // timestamp_ns[85:23], zero pad
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [7:0]             m_tdata,   // out_byte[7:0]
    output logic                   m_tlast,
    input  wire logic              cfg_valid,
    output logic                   cfg_ready,
    input  wire logic [CFG_IW-1:0] cfg_index,
    input  wire logic [POS_W-1:0]  cfg_data
);

    logic [POS_W-1:0] width_reg;
    logic [POS_W-1:0] height_reg;
    logic             job_valid;
    logic             job_ready;
    job_t             job;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_WIDTH)
            begin
                width_reg <= cfg_data;
            end
            else if (cfg_index == REG_HEIGHT)
            begin
                height_reg <= cfg_data;
            end
        end
    end

    tere_event u_event (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_tvalid      (s_tvalid),
        .s_tready      (s_tready),
        .s_tdata       (s_tdata[IN_W-1:0]),
        .screen_width  (width_reg),
        .screen_height (height_reg),
        .job_valid     (job_valid),
        .job_ready     (job_ready),
        .job           (job)
    );

    tere_msg_emit u_emit (
        .clk       (clk),
        .rst_n     (rst_n),
        .job_valid (job_valid),
        .job_ready (job_ready),
        .job       (job),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

endmodule

`default_nettype wire

>>> bench/touch_event_report_encoder_core_tb.sv
// Self-checking bench for touch_event_report_encoder_core: directed table, then random events.
// Expected message bytes come from typed directed rows or a behavioral tracker of position/button state.
// Depends on tere_pkg and the encoder RTL.
`timescale 1ns / 100ps

module touch_event_report_encoder_core_tb;
    import tere_pkg::*;

    localparam logic [4:0]        CMD_OTHER  = 5'd2;
    localparam logic [4:0]        CMD_TOP    = 5'd31;
    localparam logic [9:0]        AXIS_OTHER = 10'd2;
    localparam logic [9:0]        AXIS_TOP   = 10'h3FF;
    localparam logic [CFG_IW-1:0] REG_SPARE  = 2'd2;
    localparam logic [TS_W-1:0]   TS_MAX     = {TS_W{1'b1}};
    localparam logic [55:0]       MSG_HEAD   = 56'h03_0b_03_00_80_01_08;
    localparam logic [39:0]       MSG_TAIL   = 40'h18_00_10_00_18;
    localparam int SETTLE_CYCLES   = 8;
    localparam int HOLD_CYCLES     = 400;
    localparam int ITEMS_PER_PHASE = 43;
    localparam int NUM_PHASES      = 6;

    typedef struct packed {
        logic [TS_W-1:0] ts;
        logic [7:0]      value;
        logic [9:0]      code;
        logic [4:0]      cmd;
    } touch_event_t;

    typedef struct {
        logic [TS_W-1:0]  ts;
        logic [POS_W-1:0] x;
        logic [POS_W-1:0] y;
        logic [1:0]       act;
    } touch_msg_t;

    typedef struct {
        logic [7:0] data;
        logic       last;
    } msg_byte_t;

    typedef struct {
        touch_event_t ev;
        bit           typed;
        bit           has_msg;
        touch_msg_t   msg;
    } dir_row_t;

    logic              clk;
    logic              rst_n     = 1'b0;
    logic              s_tvalid  = 1'b0;
    logic              s_tready;
    logic [87:0]       s_tdata   = '0;
    logic              m_tvalid;
    logic              m_tready  = 1'b0;
    logic [7:0]        m_tdata;
    logic              m_tlast;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic [CFG_IW-1:0] cfg_index = '0;
    logic [POS_W-1:0]  cfg_data  = '0;

    logic [POS_W-1:0] trk_width, trk_height, trk_x, trk_y;
    bit               trk_btn, trk_btn_prev, trk_pending;

    msg_byte_t msg_q[$];
    int        err_cnt      = 0;
    int        tx_idle_pct  = 0;
    int        rx_stall_pct = 0;
    bit        hold_req     = 1'b0;
    logic      rx_hold      = 1'b0;

    touch_event_report_encoder_core uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [POS_W-1:0] scale_axis(input logic [7:0] raw,
                                                   input logic [POS_W-1:0] full);
        logic [31:0] v;
        v = 32'(raw) * 32'(full) / 32'd255;
        return (v > 32'h3FFF) ? 14'h3FFF : v[POS_W-1:0];
    endfunction

    // Updates tracked state; returns 1 when the event emits a message.
    function automatic bit track_event(input touch_event_t e, output touch_msg_t m);
        m.ts  = e.ts;
        m.x   = trk_x;
        m.y   = trk_y;
        m.act = ACT_MOVE;
        case (e.cmd)
            CMD_KEY:
            begin
                trk_btn     = (e.value != 8'd0);
                trk_pending = 1'b1;
            end
            CMD_ABS:
            begin
                if (e.code == AXIS_X)
                begin
                    trk_x       = scale_axis(e.value, trk_width);
                    trk_pending = 1'b1;
                end
                else if (e.code == AXIS_Y)
                begin
                    trk_y       = scale_axis(e.value, trk_height);
                    trk_pending = 1'b1;
                end
            end
            CMD_SYNC:
            begin
                if (trk_pending)
                begin
                    if (trk_btn && !trk_btn_prev)
                        m.act = ACT_DOWN;
                    else if (!trk_btn && trk_btn_prev)
                        m.act = ACT_UP;
                    trk_btn_prev = trk_btn;
                    trk_pending  = 1'b0;
                    return 1'b1;
                end
            end
            default: ;
        endcase
        return 1'b0;
    endfunction

    function automatic void push_varint(ref logic [7:0] q[$], input logic [63:0] v);
        logic [6:0] group;
        do
        begin
            group = v[6:0];
            v     = v >> 7;
            q.push_back({v != 0, group});
        end
        while (v != 0);
    endfunction

    function automatic void encode_touch_msg(input touch_msg_t m);
        logic [7:0] bytes[$];
        logic [7:0] adj;
        msg_byte_t  mb;
        adj = ((m.x >> 7) != 0 ? 8'd2 : 8'd1) + ((m.y >> 7) != 0 ? 8'd2 : 8'd1);
        for (int i = 6; i >= 0; i--)
            bytes.push_back(MSG_HEAD[i*8 +: 8]);
        push_varint(bytes, 64'(m.ts));
        bytes.push_back(8'h1a);
        bytes.push_back(8'h0a + adj);
        bytes.push_back(8'h0a);
        bytes.push_back(8'h04 + adj);
        bytes.push_back(8'h08);
        push_varint(bytes, 64'(m.x));
        bytes.push_back(8'h10);
        push_varint(bytes, 64'(m.y));
        for (int i = 4; i >= 0; i--)
            bytes.push_back(MSG_TAIL[i*8 +: 8]);
        bytes.push_back(8'(m.act));
        foreach (bytes[i])
        begin
            mb.data = bytes[i];
            mb.last = (i == bytes.size() - 1);
            msg_q.push_back(mb);
        end
    endfunction

    function automatic dir_row_t mk_row(input logic [4:0] cmd, input logic [9:0] code,
                                        input logic [7:0] value, input logic [TS_W-1:0] ts,
                                        input bit typed, input bit has_msg,
                                        input logic [POS_W-1:0] x, input logic [POS_W-1:0] y,
                                        input logic [1:0] act);
        dir_row_t r;
        r.ev.cmd   = cmd;
        r.ev.code  = code;
        r.ev.value = value;
        r.ev.ts    = ts;
        r.typed    = typed;
        r.has_msg  = has_msg;
        r.msg.ts   = ts;
        r.msg.x    = x;
        r.msg.y    = y;
        r.msg.act  = act;
        return r;
    endfunction

    function automatic touch_event_t rand_event(input bit want_sync);
        touch_event_t e;
        int           r;
        e.ts    = TS_W'({$urandom, $urandom} >> $urandom_range(63, 1));
        e.value = 8'($urandom);
        e.code  = 10'($urandom);
        e.cmd   = 5'($urandom);
        r = want_sync ? 70 : $urandom_range(99);
        if (r < 22)
        begin
            e.cmd  = CMD_ABS;
            e.code = AXIS_X;
        end
        else if (r < 44)
        begin
            e.cmd  = CMD_ABS;
            e.code = AXIS_Y;
        end
        else if (r < 60)
        begin
            e.cmd = CMD_KEY;
            if ($urandom_range(1) == 0)
                e.value = 8'd0;
        end
        else if (r < 85)
            e.cmd = CMD_SYNC;
        else if (r < 93)
        begin
            while (e.cmd == CMD_SYNC || e.cmd == CMD_KEY || e.cmd == CMD_ABS)
                e.cmd = 5'($urandom);
        end
        else
        begin
            e.cmd = CMD_ABS;
            while (e.code == AXIS_X || e.code == AXIS_Y)
                e.code = 10'($urandom);
        end
        if (r < 44 && $urandom_range(7) == 0)
            e.value = ($urandom_range(1) == 0) ? 8'h00 : 8'hFF;
        return e;
    endfunction

    // Call at a rising edge. Leaves s_tvalid high after the request.
    task automatic send_event(input touch_event_t e, input bit typed, input bit has_msg,
                              input touch_msg_t typed_msg);
        touch_msg_t m;
        bit         emit;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {2'b00, e};
        do
            @(posedge clk);
        while (!s_tready);
        emit = track_event(e, m);
        if (typed)
        begin
            emit = has_msg;
            m    = typed_msg;
        end
        if (emit)
            encode_touch_msg(m);
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        while (msg_q.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [POS_W-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_WIDTH)
            trk_width = val;
        else if (idx == REG_HEIGHT)
            trk_height = val;
        @(posedge clk);
    endtask

    // long receiver hold-off so the core backs up onto its input
    initial
    begin : rx_hold_ctl
        wait (hold_req);
        @(posedge clk);
        rx_hold <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        rx_hold <= 1'b0;
    end

    initial
    begin : byte_monitor
        msg_byte_t want;
        forever
        begin
            @(posedge clk);
            if (rst_n && m_tvalid && m_tready)
            begin
                if (msg_q.size() == 0)
                begin
                    $error("unexpected request: out_byte=%h last_byte=%b", m_tdata, m_tlast);
                    err_cnt++;
                end
                else
                begin
                    want = msg_q.pop_front();
                    if (m_tdata !== want.data)
                    begin
                        $error("out_byte expected %h actual %h", want.data, m_tdata);
                        err_cnt++;
                    end
                    if (m_tlast !== want.last)
                    begin
                        $error("last_byte expected %b actual %b", want.last, m_tlast);
                        err_cnt++;
                    end
                end
            end
            m_tready <= !rx_hold && ($urandom_range(99) >= rx_stall_pct);
        end
    end

    initial
    begin : stimulus
        dir_row_t         rows[$];
        touch_msg_t       no_msg;
        logic [POS_W-1:0] w, h;

        trk_width    = WIDTH_RST;
        trk_height   = HEIGHT_RST;
        trk_x        = '0;
        trk_y        = '0;
        trk_btn      = 1'b0;
        trk_btn_prev = 1'b0;
        trk_pending  = 1'b0;
        no_msg       = '{default: '0};

        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ignored events and syncs with nothing pending
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_OTHER, AXIS_X, 8'd255, TS_MAX, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, 63'd1, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_OTHER, 8'd200, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, 63'd1, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_TOP, 8'd255, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, TS_MAX, 1, 0, '0, '0, ACT_MOVE));
        // press, then down / move / up reports at the axis extremes
        rows.push_back(mk_row(CMD_KEY, AXIS_X, 8'd1, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, '0, 1, 1, '0, '0, ACT_DOWN));
        rows.push_back(mk_row(CMD_ABS, AXIS_X, 8'd255, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_Y, 8'd255, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_TOP, 8'd255, TS_MAX, 1, 1,
                              WIDTH_RST, HEIGHT_RST, ACT_MOVE));
        rows.push_back(mk_row(CMD_KEY, AXIS_X, 8'd0, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, 63'd127, 1, 1,
                              WIDTH_RST, HEIGHT_RST, ACT_UP));
        rows.push_back(mk_row(CMD_ABS, AXIS_X, 8'd0, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_Y, 8'd0, '0, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, 63'd128, 1, 1, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_KEY, AXIS_X, 8'd128, '0, 0, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_X, 8'd1, '0, 0, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_ABS, AXIS_Y, 8'd127, '0, 0, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, TS_W'({$urandom, $urandom}), 0, 0,
                              '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_TOP, AXIS_TOP, 8'd255, TS_MAX, 1, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_KEY, AXIS_X, 8'd0, '0, 0, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_KEY, AXIS_X, 8'd255, '0, 0, 0, '0, '0, ACT_MOVE));
        rows.push_back(mk_row(CMD_SYNC, AXIS_X, 8'd0, 63'h7FFF_FFFF, 0, 0, '0, '0, ACT_MOVE));

        foreach (rows[i])
            send_event(rows[i].ev, rows[i].typed, rows[i].has_msg, rows[i].msg);
        drain();

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            case (p)
                0:
                begin
                    w = 14'h3FFF;
                    h = 14'h3FFF;
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                1:
                begin
                    w = 14'd1;
                    h = 14'd1;
                    tx_idle_pct  = 83;
                    rx_stall_pct = 0;
                end
                2:
                begin
                    w = 14'd0;
                    h = 14'd255;
                    tx_idle_pct  = 0;
                    rx_stall_pct = 83;
                end
                3:
                begin
                    w = 14'($urandom_range(16383, 1));
                    h = 14'($urandom_range(16383, 1));
                    tx_idle_pct  = 33;
                    rx_stall_pct = 33;
                end
                4:
                begin
                    w = 14'($urandom_range(16383, 1));
                    h = 14'h3FFF;
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
                default:
                begin
                    w = WIDTH_RST;
                    h = HEIGHT_RST;
                    tx_idle_pct  = 0;
                    rx_stall_pct = 0;
                end
            endcase
            write_reg(REG_WIDTH, w);
            write_reg(REG_HEIGHT, h);
            if (p == 2)
                write_reg(REG_SPARE, 14'($urandom));
            if (p == 4)
                hold_req = 1'b1;
            for (int i = 0; i < ITEMS_PER_PHASE; i++)
                send_event(rand_event(p == 4 && i % 2 == 1), 0, 0, no_msg);
            drain();
        end

        if (msg_q.size() != 0)
        begin
            $error("%0d expected bytes never arrived", msg_q.size());
            err_cnt++;
        end
        if (err_cnt == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

>>> sim.f
rtl/tere_pkg.sv
rtl/tere_event.sv
rtl/tere_msg_emit.sv
rtl/touch_event_report_encoder_core.sv
bench/touch_event_report_encoder_core_tb.sv
